// ===== hdl/rws_pkg.sv =====
// ----------------------------------------------------------------------------
// rws_pkg - shared types and constants of the RIFF/WAVE format sniffer
// Widths, header identifiers, walk phase codes, verdict codes and the
// control structs that pass between the sniffer's modules.
// ----------------------------------------------------------------------------
package rws_pkg;

	// Prefix window and derived widths
	localparam int PREFIX_BYTES = 256;
	localparam int POS_W        = 17;
	localparam int BND_W        = 34;
	localparam int LEN_W        = 32;
	localparam int TAG_W        = 16;
	localparam int KIND_W       = 3;

	// Walk phases
	localparam logic [2:0] PH_HEADER   = 3'd0;
	localparam logic [2:0] PH_CHUNK_HDR = 3'd1;
	localparam logic [2:0] PH_SKIP     = 3'd2;
	localparam logic [2:0] PH_FMT      = 3'd3;
	localparam logic [2:0] PH_FOUND    = 3'd4;
	localparam logic [2:0] PH_FAIL     = 3'd5;

	// Verdict codes
	localparam logic [KIND_W-1:0] KIND_PCM_WAV      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MSADPCM_WAV  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_IMAADPCM_WAV = 3'd2;
	localparam logic [KIND_W-1:0] KIND_MP3_WAV      = 3'd3;
	localparam logic [KIND_W-1:0] KIND_OTHER_WAV    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_MP3          = 3'd5;
	localparam logic [KIND_W-1:0] KIND_CORRUPT_WAV  = 3'd6;
	localparam logic [KIND_W-1:0] KIND_UNSUPPORTED  = 3'd7;

	// Format tags with a class of their own
	localparam logic [TAG_W-1:0] TAG_PCM      = 16'd1;
	localparam logic [TAG_W-1:0] TAG_MSADPCM  = 16'd2;
	localparam logic [TAG_W-1:0] TAG_IMAADPCM = 16'd17;
	localparam logic [TAG_W-1:0] TAG_MP3      = 16'd85;

	// Header flag bits
	localparam int FLG_RIFF = 0;
	localparam int FLG_WAVE = 1;
	localparam int FLG_ID3  = 2;
	localparam int FLG_SYNC = 3;

	localparam logic [7:0] SYNC_BYTE = 8'hff;
	localparam logic [7:0] SYNC_MASK = 8'he0;

	// Identifier bytes, first byte in the lowest lane
	localparam logic [7:0] RIFF_ID [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
	localparam logic [7:0] WAVE_ID [4] = '{8'h57, 8'h41, 8'h56, 8'h45};
	localparam logic [7:0] FMT_ID  [4] = '{8'h66, 8'h6d, 8'h74, 8'h20};
	localparam logic [7:0] ID3_ID  [3] = '{8'h49, 8'h44, 8'h33};

	// One prefix byte as presented to the tracking modules
	typedef struct packed {
		logic             adv;    // byte leaves the input register
		logic             last;   // final byte: restart afterwards
		logic             take;   // byte lies inside the prefix window
		logic [POS_W-1:0] pos;
		logic [7:0]       data;
	} step_t;

	// Position before and after the current byte, and header flags after it
	typedef struct packed {
		logic [POS_W-1:0] pos_q;
		logic [POS_W-1:0] pos_nxt;
		logic [3:0]       flags_nxt;
	} hdr_stat_t;

	// Walk outcome after the current byte
	typedef struct packed {
		logic             found;
		logic [TAG_W-1:0] tag;
	} walk_stat_t;

	// Class a found format tag
	function automatic logic [KIND_W-1:0] kind_of_tag(input logic [TAG_W-1:0] tag);
		logic [KIND_W-1:0] k;
		case (tag)
			TAG_PCM:      k = KIND_PCM_WAV;
			TAG_MSADPCM:  k = KIND_MSADPCM_WAV;
			TAG_IMAADPCM: k = KIND_IMAADPCM_WAV;
			TAG_MP3:      k = KIND_MP3_WAV;
			default:      k = KIND_OTHER_WAV;
		endcase
		return k;
	endfunction

endpackage

// ===== hdl/rws_if.sv =====
// ----------------------------------------------------------------------------
// rws_if - byte and verdict channels of the format sniffer
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface rws_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface rws_verdict_if;
	logic                         valid;
	logic                         ready;
	logic [rws_pkg::KIND_W-1:0]   kind;
	logic [rws_pkg::TAG_W-1:0]    format_tag;

	modport source (output valid, output kind, output format_tag, input ready);
	modport sink   (input valid, input kind, input format_tag, output ready);
endinterface

// ===== hdl/riff_wave_format_sniffer.sv =====
// ----------------------------------------------------------------------------
// riff_wave_format_sniffer - audio file format sniffer
// Classifies a file prefix, given a byte at a time, as RIFF/WAVE by format
// tag, as mp3, as corrupt WAV or as unsupported.
//
//   channel   role     payload                 transfer
//   prefix    sink     data_byte[7:0], last    valid & ready
//   verdict   source   kind[2:0], format_tag   valid & ready, one per last
//
// One byte per cycle while no stalled verdict holds the byte marked last: a
// byte waits in the input register; as it leaves, position, flags and chunk
// walk take its update and, for the final byte, the verdict is registered.
// Reset clears all state to an empty prefix; after each verdict the state
// returns to it so the next byte opens a new prefix.
// A stalled verdict stalls only the byte marked last; other bytes flow on.
// ----------------------------------------------------------------------------
module riff_wave_format_sniffer (
	input logic             clk,
	input logic             arst_n,
	rws_byte_if.sink        prefix,
	rws_verdict_if.source   verdict
);

	logic                        valid_s1;
	logic [7:0]                  data_s1;
	logic                        last_s1;
	logic                        adv;
	logic                        res_valid_q;
	logic [rws_pkg::KIND_W-1:0]  kind_q;
	logic [rws_pkg::TAG_W-1:0]   tag_q;
	logic [rws_pkg::KIND_W-1:0]  kind_nxt;
	logic [rws_pkg::TAG_W-1:0]   tag_nxt;
	rws_pkg::hdr_stat_t          hdr;
	rws_pkg::walk_stat_t         walk;
	rws_pkg::step_t              step;

	// Byte leaves the input register unless it needs a busy result slot
	assign adv = valid_s1 && (!last_s1 || !res_valid_q || verdict.ready);
	assign prefix.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (prefix.ready) begin
			valid_s1 <= prefix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prefix.valid && prefix.ready) begin
			data_s1 <= prefix.data_byte;
			last_s1 <= prefix.last;
		end
	end

	rws_hdr u_hdr (
		.clk    (clk),
		.arst_n (arst_n),
		.data   (data_s1),
		.adv    (adv),
		.last   (last_s1),
		.stat   (hdr)
	);

	assign step.adv  = adv;
	assign step.last = last_s1;
	assign step.take = (hdr.pos_q != hdr.pos_nxt);
	assign step.pos  = hdr.pos_q;
	assign step.data = data_s1;

	rws_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.stat   (walk)
	);

	// Form the verdict from the state after this byte
	always_comb begin
		tag_nxt = '0;
		if (hdr.pos_nxt >= 17'd12 && hdr.flags_nxt[rws_pkg::FLG_RIFF]
				&& hdr.flags_nxt[rws_pkg::FLG_WAVE]) begin
			if (walk.found) begin
				tag_nxt  = walk.tag;
				kind_nxt = rws_pkg::kind_of_tag(walk.tag);
			end else begin
				kind_nxt = rws_pkg::KIND_CORRUPT_WAV;
			end
		end else if (hdr.pos_nxt >= 17'd3 && (hdr.flags_nxt[rws_pkg::FLG_ID3]
				|| hdr.flags_nxt[rws_pkg::FLG_SYNC])) begin
			kind_nxt = rws_pkg::KIND_MP3;
		end else begin
			kind_nxt = rws_pkg::KIND_UNSUPPORTED;
		end
	end

	// Result register: drop on transfer, load on the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (verdict.valid && verdict.ready)
				res_valid_q <= 1'b0;
			if (adv && last_s1)
				res_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			kind_q <= kind_nxt;
			tag_q  <= tag_nxt;
		end
	end

	assign verdict.valid      = res_valid_q;
	assign verdict.kind       = kind_q;
	assign verdict.format_tag = tag_q;

endmodule

// ===== hdl/rws_hdr.sv =====
// ----------------------------------------------------------------------------
// rws_hdr - byte position and header signature flags
// Counts prefix bytes up to the window size and clears a flag as soon as
// a byte contradicts the RIFF, WAVE, ID3 or MPEG sync signature.
// ----------------------------------------------------------------------------
module rws_hdr (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data,
	input  logic                adv,
	input  logic                last,
	output rws_pkg::hdr_stat_t  stat
);

	logic [rws_pkg::POS_W-1:0] pos_q;
	logic [3:0]                flags_q;
	logic                      take;
	logic [3:0]                flags_nxt;
	logic [rws_pkg::POS_W-1:0] pos_nxt;

	assign take = (pos_q < rws_pkg::POS_W'(rws_pkg::PREFIX_BYTES));

	// Clear flags on mismatching signature bytes
	always_comb begin
		flags_nxt = flags_q;
		if (take) begin
			if (pos_q < 17'd4 && data != rws_pkg::RIFF_ID[pos_q[1:0]])
				flags_nxt[rws_pkg::FLG_RIFF] = 1'b0;
			if (pos_q >= 17'd8 && pos_q < 17'd12 && data != rws_pkg::WAVE_ID[pos_q[1:0]])
				flags_nxt[rws_pkg::FLG_WAVE] = 1'b0;
			if (pos_q < 17'd3 && data != rws_pkg::ID3_ID[pos_q[1:0]])
				flags_nxt[rws_pkg::FLG_ID3] = 1'b0;
			if (pos_q == 17'd0 && data != rws_pkg::SYNC_BYTE)
				flags_nxt[rws_pkg::FLG_SYNC] = 1'b0;
			if (pos_q == 17'd1 && (data & rws_pkg::SYNC_MASK) != rws_pkg::SYNC_MASK)
				flags_nxt[rws_pkg::FLG_SYNC] = 1'b0;
		end
	end

	assign pos_nxt = take ? pos_q + 17'd1 : pos_q;

	// Advance on each transfer, restart after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			flags_q <= 4'hf;
		end else if (adv) begin
			if (last) begin
				pos_q   <= '0;
				flags_q <= 4'hf;
			end else begin
				pos_q   <= pos_nxt;
				flags_q <= flags_nxt;
			end
		end
	end

	assign stat.pos_q     = pos_q;
	assign stat.pos_nxt   = pos_nxt;
	assign stat.flags_nxt = flags_nxt;

endmodule

// ===== hdl/rws_walk.sv =====
// ----------------------------------------------------------------------------
// rws_walk - RIFF chunk walker
// Follows the chunk list from offset 12, skipping bodies (odd sizes padded)
// until the first "fmt " chunk yields its format tag; one under two bytes fails.
// ----------------------------------------------------------------------------
module rws_walk (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rws_pkg::step_t       step,
	output rws_pkg::walk_stat_t  stat
);

	logic [2:0]                phase_q, phase_nxt;
	logic                      is_fmt_q, is_fmt_nxt;
	logic [rws_pkg::LEN_W-1:0] len_q, len_nxt;
	logic [rws_pkg::BND_W-1:0] bnd_q, bnd_nxt;
	logic [rws_pkg::TAG_W-1:0] tag_q, tag_nxt;
	logic [2:0]                idx_q, idx_nxt;
	logic [1:0]                tcnt_q, tcnt_nxt;
	logic                      at_bnd;
	logic [rws_pkg::BND_W-1:0] len_ext;

	assign at_bnd  = ((rws_pkg::BND_W'(step.pos) + 34'd1) == bnd_q);
	assign len_ext = rws_pkg::BND_W'(len_nxt);

	// Next walk state for the byte in the input register
	always_comb begin
		phase_nxt  = phase_q;
		is_fmt_nxt = is_fmt_q;
		len_nxt    = len_q;
		bnd_nxt    = bnd_q;
		tag_nxt    = tag_q;
		idx_nxt    = idx_q;
		tcnt_nxt   = tcnt_q;
		if (step.take) begin
			case (phase_q)
				rws_pkg::PH_HEADER, rws_pkg::PH_SKIP: begin
					if (at_bnd) begin
						phase_nxt  = rws_pkg::PH_CHUNK_HDR;
						bnd_nxt    = bnd_q + 34'd8;
						is_fmt_nxt = 1'b1;
						idx_nxt    = 3'd0;
					end
				end
				rws_pkg::PH_CHUNK_HDR: begin
					// id bytes check the name, size bytes shift in low first
					if (idx_q[2])
						len_nxt = {step.data, len_q[rws_pkg::LEN_W-1:8]};
					else if (step.data != rws_pkg::FMT_ID[idx_q[1:0]])
						is_fmt_nxt = 1'b0;
					idx_nxt = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						if (is_fmt_nxt) begin
							if (len_nxt < 32'd2) begin
								phase_nxt = rws_pkg::PH_FAIL;
							end else begin
								phase_nxt = rws_pkg::PH_FMT;
								bnd_nxt   = bnd_q + len_ext;
								tcnt_nxt  = 2'd0;
							end
						end else if (len_nxt == '0) begin
							bnd_nxt    = bnd_q + 34'd8;
							is_fmt_nxt = 1'b1;
							idx_nxt    = 3'd0;
						end else begin
							phase_nxt = rws_pkg::PH_SKIP;
							bnd_nxt   = bnd_q + len_ext + rws_pkg::BND_W'(len_nxt[0]);
						end
					end
				end
				rws_pkg::PH_FMT: begin
					// first two body bytes carry the tag, low byte first
					if (tcnt_q == 2'd0) begin
						tag_nxt  = {8'h00, step.data};
						tcnt_nxt = 2'd1;
					end else if (tcnt_q == 2'd1) begin
						tag_nxt[15:8] = step.data;
						tcnt_nxt      = 2'd2;
					end
					if (at_bnd)
						phase_nxt = rws_pkg::PH_FOUND;
				end
				default: begin
				end
			endcase
		end
	end

	// Hold walk state, restart after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rws_pkg::PH_HEADER;
			is_fmt_q <= 1'b0;
			len_q    <= '0;
			bnd_q    <= 34'd12;
			tag_q    <= '0;
			idx_q    <= '0;
			tcnt_q   <= '0;
		end else if (step.adv) begin
			if (step.last) begin
				phase_q  <= rws_pkg::PH_HEADER;
				is_fmt_q <= 1'b0;
				len_q    <= '0;
				bnd_q    <= 34'd12;
				tag_q    <= '0;
				idx_q    <= '0;
				tcnt_q   <= '0;
			end else begin
				phase_q  <= phase_nxt;
				is_fmt_q <= is_fmt_nxt;
				len_q    <= len_nxt;
				bnd_q    <= bnd_nxt;
				tag_q    <= tag_nxt;
				idx_q    <= idx_nxt;
				tcnt_q   <= tcnt_nxt;
			end
		end
	end

	assign stat.found = (phase_nxt == rws_pkg::PH_FOUND);
	assign stat.tag   = tag_nxt;

endmodule
